/* rtl/tfl_pkg.sv */
// tfl_pkg: shared types, constants and the coefficient table of the
// three-axis fir low-pass filter
// no dependencies
package tfl_pkg;

   // field widths fixed by the interface
   localparam int AXIS_W  = 2;
   localparam int FIELD_W = 16;

   // axis code that passes the sample through unfiltered
   localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

   // hanning window, rounded to q1.15, symmetric
   localparam int TABLE_TAPS = 17;
   localparam int WINDOW_Q15 [TABLE_TAPS] = '{
      0, 66, 346, 920, 1771, 2777, 3737, 4428, 4680,
      4428, 3737, 2777, 1771, 920, 346, 66, 0
   };

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear;
      logic accept;
      logic issue;
      logic load_out;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic req_bypass;
      logic tap_last;
      logic pipe_busy;
   } dp_status_type;

   // coefficient of one tap rescaled to frac fraction bits; zero past the table
   function automatic int coef_at(input int tap, input int frac);
      int c;
      int r;
      begin
         c = 0;
         if (tap >= 0 && tap < TABLE_TAPS) begin
            c = WINDOW_Q15[tap];
         end
         if (frac >= 15) begin
            r = c <<< (frac - 15);
         end else begin
            r = (c + (1 <<< (14 - frac))) >>> (15 - frac);
         end
         return r;
      end
   endfunction

endpackage

/* rtl/three_axis_fir_lowpass.sv */
// Three-axis FIR low-pass filter. Each request carries an axis (0 x, 1 y,
// 2 z, 3 none) and a signed sample; axes x, y and z each keep a circular row
// of FILTER_ORDER+1 samples, and the response is the sum of the newest
// samples times fixed symmetric Hanning coefficients, rounded half up and
// saturated. Axis none, or an axis without a channel, returns the sample
// unchanged and leaves the store alone. One request is in work at a time:
// a filtered request is summed by the single shared multiply-accumulate,
// which walks the taps one store read per cycle; a pass-through request
// skips the tap walk. A finished result waits in the output register while
// the next request is taken. After reset the sample store is cleared one
// entry per cycle, with req_stall held high.
// top level; depends on tfl_pkg, tfl_ctrl and tfl_datapath
module three_axis_fir_lowpass #(
   parameter int FILTER_ORDER   = 16,
   parameter int CHANNELS       = 3,
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic        [tfl_pkg::AXIS_W-1:0]  req_axis,
   input  logic signed [tfl_pkg::FIELD_W-1:0] req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic        [tfl_pkg::AXIS_W-1:0]  rsp_axis_out,
   output logic signed [tfl_pkg::FIELD_W-1:0] rsp_filtered_sample
);

   tfl_pkg::ctrl_cmd_type  cmd;
   tfl_pkg::dp_status_type stat;

   // sequencing
   tfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // store and arithmetic
   tfl_datapath #(
      .FILTER_ORDER   (FILTER_ORDER),
      .CHANNELS       (CHANNELS),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_axis            (req_axis),
      .req_sample          (req_sample),
      .rsp_axis_out        (rsp_axis_out),
      .rsp_filtered_sample (rsp_filtered_sample),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule

/* rtl/tfl_ctrl.sv */
// tfl_ctrl: controller state machine of the three-axis fir low-pass filter
// sequences store clearing, request intake, tap issue and result hand-off
// depends on tfl_pkg
module tfl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tfl_pkg::ctrl_cmd_type  cmd,
   input  tfl_pkg::dp_status_type stat
);

   tfl_pkg::ctrl_state_type state_ff;
   tfl_pkg::ctrl_state_type state_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    out_free;

   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfl_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         tfl_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = tfl_pkg::ST_IDLE;
            end
         end
         tfl_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.req_bypass ? tfl_pkg::ST_FINISH : tfl_pkg::ST_RUN;
            end
         end
         tfl_pkg::ST_RUN: begin
            cmd.issue = 1'b1;
            if (stat.tap_last) begin
               state_in = tfl_pkg::ST_FINISH;
            end
         end
         tfl_pkg::ST_FINISH: begin
            if (!stat.pipe_busy && out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tfl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tfl_pkg::ST_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != tfl_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // a new result never overwrites one that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a stalled result");

   // a taken result without a new one leaves the output empty
   a_rsp_retire: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !cmd.load_out) |=> !rsp_valid_ff)
      else $error("result delivered twice");

   // tap issue only ends in the finish state
   a_run_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfl_pkg::ST_RUN) |=>
         (state_ff == tfl_pkg::ST_RUN || state_ff == tfl_pkg::ST_FINISH))
      else $error("tap issue left early");
`endif

endmodule

/* rtl/tfl_datapath.sv */
// tfl_datapath: sample store, write positions, multiply-accumulate pipeline,
// rounding and saturation, and the result register of the fir low-pass filter
// depends on tfl_pkg
module tfl_datapath #(
   parameter int FILTER_ORDER   = 16,
   parameter int CHANNELS       = 3,
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic        [tfl_pkg::AXIS_W-1:0]    req_axis,
   input  logic signed [tfl_pkg::FIELD_W-1:0]   req_sample,
   output logic        [tfl_pkg::AXIS_W-1:0]    rsp_axis_out,
   output logic signed [tfl_pkg::FIELD_W-1:0]   rsp_filtered_sample,
   input  tfl_pkg::ctrl_cmd_type                cmd,
   output tfl_pkg::dp_status_type               stat
);

   localparam int TAPS   = FILTER_ORDER + 1;
   localparam int DEPTH  = CHANNELS * TAPS;
   localparam int AW     = $clog2(DEPTH);
   localparam int PTW    = $clog2(TAPS);
   localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SW     = SAMPLE_WIDTH;
   localparam int CF     = COEF_FRAC_BITS;
   localparam int PW     = SW + CF;
   localparam int ACC_W  = PW + $clog2(TAPS) + 1;
   localparam int RAW_W  = (SW > tfl_pkg::FIELD_W) ? SW : tfl_pkg::FIELD_W;
   localparam int HI_INT = (1 <<< (SW - 1)) - 1;
   localparam int LO_INT = -(1 <<< (SW - 1));
   localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(1 <<< (CF - 1));
   localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'(HI_INT);
   localparam logic signed [ACC_W:0] SAT_LO = (ACC_W + 1)'(LO_INT);

   // sample store, one row of taps per channel
   logic signed [SW-1:0]     mem [DEPTH];
   logic [PTW-1:0]           pos_ff [CHANNELS];

   logic [AW-1:0]            clr_ff;
   logic [AW-1:0]            base_ff;
   logic [PTW-1:0]           rptr_ff;
   logic [PTW-1:0]           tap_ff;
   logic [tfl_pkg::AXIS_W-1:0] axis_ff;
   logic signed [SW-1:0]     x_ff;
   logic                     bypass_ff;

   logic signed [SW-1:0]     rd_data_ff;
   logic signed [CF-1:0]     coef_ff;
   logic                     s1_vld_ff;
   logic signed [PW-1:0]     prod_ff;
   logic                     s2_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic [tfl_pkg::AXIS_W-1:0]        rsp_axis_ff;
   logic signed [tfl_pkg::FIELD_W-1:0] rsp_sample_ff;

   logic [CHW-1:0]           chan;
   logic [PTW-1:0]           cur_pos;
   logic [AW-1:0]            base_in;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr;
   logic [RAW_W-1:0]         x_wide;
   logic signed [SW-1:0]     x_in;
   logic                     bypass_in;
   logic signed [ACC_W:0]    sum_w;
   logic signed [ACC_W:0]    shifted;
   logic signed [SW-1:0]     sat_w;

   // decode of the incoming request
   assign chan      = CHW'(req_axis);
   assign bypass_in = (req_axis == tfl_pkg::AXIS_NONE) || (int'(req_axis) >= CHANNELS);
   assign cur_pos   = pos_ff[chan];
   assign base_in   = AW'(int'(chan) * TAPS);
   assign wr_addr   = AW'(base_in + AW'(cur_pos));
   assign rd_addr   = AW'(base_ff + AW'(rptr_ff));

   // low sample bits, sign-extended from the sample width
   assign x_wide = RAW_W'($unsigned(req_sample));
   assign x_in   = $signed(x_wide[SW-1:0]);

   // clear sweep counter and per-channel write positions
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
         end
      end else begin
         if (cmd.clear) begin
            clr_ff <= AW'(clr_ff + 1'b1);
         end
         if (cmd.accept && !bypass_in) begin
            pos_ff[chan] <= (cur_pos == PTW'(TAPS - 1)) ? '0 : PTW'(cur_pos + 1'b1);
         end
      end
   end

   // sample store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_ff] <= '0;
      end else if (cmd.accept && !bypass_in) begin
         mem[wr_addr] <= x_in;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // request capture and tap walk, newest sample first
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         axis_ff   <= req_axis;
         x_ff      <= x_in;
         bypass_ff <= bypass_in;
         base_ff   <= base_in;
         rptr_ff   <= cur_pos;
         tap_ff    <= '0;
      end else if (cmd.issue) begin
         rptr_ff <= (rptr_ff == '0) ? PTW'(TAPS - 1) : PTW'(rptr_ff - 1'b1);
         tap_ff  <= PTW'(tap_ff + 1'b1);
      end
   end

   // coefficient lookup alongside the store read
   always_ff @(posedge clock) begin
      coef_ff <= CF'(tfl_pkg::coef_at(int'(tap_ff), CF));
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // multiply then accumulate
   always_ff @(posedge clock) begin
      prod_ff <= PW'(rd_data_ff * coef_ff);
      if (cmd.accept) begin
         acc_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_ff <= ACC_W'(acc_ff + ACC_W'(prod_ff));
      end
   end

   // round half up, drop fraction bits, saturate to the sample range
   always_comb begin
      sum_w   = (ACC_W + 1)'(acc_ff) + HALF;
      shifted = sum_w >>> CF;
      if (shifted > SAT_HI) begin
         sat_w = SAT_HI[SW-1:0];
      end else if (shifted < SAT_LO) begin
         sat_w = SAT_LO[SW-1:0];
      end else begin
         sat_w = shifted[SW-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_axis_ff   <= axis_ff;
         rsp_sample_ff <= bypass_ff ? tfl_pkg::FIELD_W'(x_ff) : tfl_pkg::FIELD_W'(sat_w);
      end
   end

   assign rsp_axis_out        = rsp_axis_ff;
   assign rsp_filtered_sample = rsp_sample_ff;

   // status to the controller
   assign stat.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign stat.req_bypass = bypass_in;
   assign stat.tap_last   = (tap_ff == PTW'(TAPS - 1));
   assign stat.pipe_busy  = s1_vld_ff || s2_vld_ff;

`ifndef NO_ASSERTIONS
   // the accumulator is complete before a result is taken from it
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("result taken with products in flight");

   // write position of a filtered channel stays inside its row
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !bypass_in) |-> (int'(cur_pos) < TAPS))
      else $error("write position out of range");

   // a product only follows a store read
   a_stage_order: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> $past(s1_vld_ff))
      else $error("product without a store read");
`endif

endmodule
